>>> rtl/s20sc_pkg.sv
// ----------------------------------------------------------------------------
// s20sc_pkg: shared types, constants and round functions
// Types, constants and the Salsa20 round functions that are shared by the
// front, the core and the back of the stream cipher.
// ----------------------------------------------------------------------------
package s20sc_pkg;

  // Rounds are executed in column/row pairs, so an odd count rounds up.
  localparam int unsigned ROUND_COUNT = 20;
  localparam int unsigned ROUNDS_RUN  = 2 * ((ROUND_COUNT + 1) / 2);
  localparam int unsigned RND_W       = $clog2(ROUNDS_RUN);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] C_EXPA = 32'h61707865;
  localparam logic [31:0] C_ND3  = 32'h3320646e;
  localparam logic [31:0] C_2BY  = 32'h79622d32;
  localparam logic [31:0] C_TEK  = 32'h6b206574;
  localparam logic [31:0] C_ND1  = 32'h3120646e;
  localparam logic [31:0] C_6BY  = 32'h79622d36;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][31:0]  quad_t;

  typedef enum logic [2:0] {
    REG_KEY_0_7   = 3'd0,
    REG_KEY_8_15  = 3'd1,
    REG_KEY_16_23 = 3'd2,
    REG_KEY_24_31 = 3'd3,
    REG_LONG_KEY  = 3'd4,
    REG_NONCE     = 3'd5
  } cfg_reg_t;

  // One request as classified by the front.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic [7:0]  byte_en;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // One quarter-round on the words at positions a, b, c and d.
  function automatic state_t quarter(state_t s, int unsigned a, int unsigned b,
                                     int unsigned c, int unsigned d);
    state_t r;
    r    = s;
    r[b] = r[b] ^ rotl(word_t'(r[a] + r[d]), 7);
    r[c] = r[c] ^ rotl(word_t'(r[b] + r[a]), 9);
    r[d] = r[d] ^ rotl(word_t'(r[c] + r[b]), 13);
    r[a] = r[a] ^ rotl(word_t'(r[d] + r[c]), 18);
    return r;
  endfunction

  // The four quarter-rounds of one round touch disjoint words.
  function automatic state_t salsa_round(state_t s, logic row_rnd);
    state_t r;
    r = s;
    if (row_rnd) begin
      r = quarter(r, 0, 1, 2, 3);
      r = quarter(r, 5, 6, 7, 4);
      r = quarter(r, 10, 11, 8, 9);
      r = quarter(r, 15, 12, 13, 14);
    end else begin
      r = quarter(r, 0, 4, 8, 12);
      r = quarter(r, 5, 9, 13, 1);
      r = quarter(r, 10, 14, 2, 6);
      r = quarter(r, 15, 3, 7, 11);
    end
    return r;
  endfunction

endpackage

>>> rtl/s20sc_front.sv
// ----------------------------------------------------------------------------
// s20sc_front: request intake and queue
// Accepts requests, limits the byte count, derives the byte enables and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module s20sc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_data_in,
  input  logic [3:0]         in_byte_count,
  input  logic               in_message_end,
  output s20sc_pkg::q_head_t head,
  input  logic               pop
);
  import s20sc_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push;
  item_t              new_item;
  logic [3:0]         cnt_lim;

  assign in_stall = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid & ~in_stall;

  always_comb begin
    cnt_lim = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
    new_item.data = in_data_in;
    new_item.cnt  = cnt_lim;
    new_item.last = in_message_end;
    for (int i = 0; i < 8; i++) begin
      new_item.byte_en[i] = (4'(i) < cnt_lim);
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

endmodule

>>> rtl/s20sc_core.sv
// ----------------------------------------------------------------------------
// s20sc_core: Salsa20 round engine
// Runs one round per cycle on the working state and adds the initial state
// back in to form the keystream block.
// ----------------------------------------------------------------------------
module s20sc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  s20sc_pkg::state_t    init,
  output s20sc_pkg::core_sts_t sts,
  output s20sc_pkg::state_t    ks
);
  import s20sc_pkg::*;

  state_t           work_r;
  logic [RND_W-1:0] rnd_r;
  logic             busy_r;
  logic             done_r;
  logic             last_rnd;

  assign last_rnd = (rnd_r == RND_W'(ROUNDS_RUN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + RND_W'(1);
        if (last_rnd) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Even rounds work on columns, odd rounds on rows.
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= init;
    end else if (busy_r) begin
      work_r <= salsa_round(work_r, rnd_r[0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks[i] = work_r[i] + init[i];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> rtl/s20sc_back.sv
// ----------------------------------------------------------------------------
// s20sc_back: configuration, sequencing and output stage
// Holds the key, nonce and block counter, starts the round engine at each
// new block, stores the keystream and XORs it into the queued requests.
// ----------------------------------------------------------------------------
module s20sc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  s20sc_pkg::q_head_t   head,
  output logic                 pop,
  output logic                 core_start,
  output s20sc_pkg::state_t    core_init,
  input  s20sc_pkg::core_sts_t core_sts,
  input  s20sc_pkg::state_t    core_ks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_data_out,
  output logic [3:0]           out_count,
  output logic                 out_last
);
  import s20sc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_GEN  = 3'b010,
    ST_EMIT = 3'b100
  } st_t;

  st_t         st_r, st_nxt;
  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r;
  logic        long_key_r;
  logic [63:0] blk_cnt_r;
  logic [2:0]  wp_r;
  logic [63:0] ks_r [8];
  logic        cfg_wr;
  logic        out_free;
  logic        emit;
  logic [63:0] k2, k3;
  logic [63:0] xored;
  logic [63:0] data_nxt;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_count_r;
  logic        out_last_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      long_key_r <= 1'b1;
      nonce_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_0_7:   key0_r     <= cfg_data;
        REG_KEY_8_15:  key1_r     <= cfg_data;
        REG_KEY_16_23: key2_r     <= cfg_data;
        REG_KEY_24_31: key3_r     <= cfg_data;
        REG_LONG_KEY:  long_key_r <= cfg_data[0];
        REG_NONCE:     nonce_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A short key fills the second key half with the first one again.
  always_comb begin
    k2 = long_key_r ? key2_r : key0_r;
    k3 = long_key_r ? key3_r : key1_r;
    core_init[0]  = C_EXPA;
    core_init[1]  = key0_r[31:0];
    core_init[2]  = key0_r[63:32];
    core_init[3]  = key1_r[31:0];
    core_init[4]  = key1_r[63:32];
    core_init[5]  = long_key_r ? C_ND3 : C_ND1;
    core_init[6]  = nonce_r[31:0];
    core_init[7]  = nonce_r[63:32];
    core_init[8]  = blk_cnt_r[31:0];
    core_init[9]  = blk_cnt_r[63:32];
    core_init[10] = long_key_r ? C_2BY : C_6BY;
    core_init[11] = k2[31:0];
    core_init[12] = k2[63:32];
    core_init[13] = k3[31:0];
    core_init[14] = k3[63:32];
    core_init[15] = C_TEK;
  end

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    st_nxt     = st_r;
    emit       = 1'b0;
    core_start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (head.valid) begin
          if (wp_r == 3'd0) begin
            core_start = 1'b1;
            st_nxt     = ST_GEN;
          end else begin
            emit = out_free;
          end
        end
      end
      ST_GEN: begin
        if (core_sts.done) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit = out_free;
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign pop = emit;

  always_comb begin
    xored = head.item.data ^ ks_r[wp_r];
    for (int i = 0; i < 8; i++) begin
      data_nxt[8*i +: 8] = head.item.byte_en[i] ? xored[8*i +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      blk_cnt_r   <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      priority if (cfg_wr && cfg_reg_t'(cfg_index) == REG_NONCE) begin
        blk_cnt_r <= '0;
      end else if (st_r == ST_GEN && core_sts.done) begin
        blk_cnt_r <= blk_cnt_r + 64'd1;
      end else begin
        blk_cnt_r <= blk_cnt_r;
      end
      if (emit) begin
        wp_r        <= head.item.last ? 3'd0 : wp_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_GEN && core_sts.done) begin
      for (int i = 0; i < 8; i++) begin
        ks_r[i] <= {core_ks[2*i+1], core_ks[2*i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r  <= data_nxt;
      out_count_r <= head.item.cnt;
      out_last_r  <= head.item.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_count    = out_count_r;
  assign out_last     = out_last_r;

endmodule

>>> rtl/salsa20_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// salsa20_stream_cipher_top: Salsa20 stream cipher, 8 bytes per request
// Top level joining the request queue, the round engine and the back end.
// ----------------------------------------------------------------------------
// Each request carries up to eight little-endian bytes and returns them XORed
// with the next eight keystream bytes, bytes past the count cleared. The first
// request of a 64-byte block waits for the round engine, which runs one round
// per cycle (20 rounds by default): start, rounds, keystream store, output.
// The other seven requests of the block leave at one per cycle while the
// receiver does not stall. A request with message_end set discards the rest
// of the block. A two-entry queue in front keeps accepting requests while
// the engine works, and the output register holds a result while the
// receiver stalls. The user must write key, mode and nonce through the cfg_
// port only while no request is outstanding; the block does not enforce
// this. A nonce write clears the block counter.
module salsa20_stream_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_in,
  input  logic [3:0]  in_byte_count,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out,
  output logic [3:0]  out_count,
  output logic        out_last
);
  import s20sc_pkg::*;

  q_head_t   head;
  logic      pop;
  logic      core_start;
  state_t    core_init;
  state_t    core_ks;
  core_sts_t core_sts;

  s20sc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_in     (in_data_in),
    .in_byte_count  (in_byte_count),
    .in_message_end (in_message_end),
    .head           (head),
    .pop            (pop)
  );

  s20sc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .init  (core_init),
    .sts   (core_sts),
    .ks    (core_ks)
  );

  s20sc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .pop          (pop),
    .core_start   (core_start),
    .core_init    (core_init),
    .core_sts     (core_sts),
    .core_ks      (core_ks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_count    (out_count),
    .out_last     (out_last)
  );

endmodule

>>> rtl/s20sc_checker.sv
// ----------------------------------------------------------------------------
// s20sc_checker: port-level checks for the stream cipher
// Watches the result channel and the request stall of the top level over time.
// ----------------------------------------------------------------------------
module s20sc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_data_out,
  input logic [3:0]  out_count,
  input logic        out_last
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out) &&
      $stable(out_count) && $stable(out_last))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= 4'd8)
    else $error("result byte count above eight");

  // Bytes past the count must be cleared.
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count < 4'd8 |-> (out_data_out >> {out_count, 3'b000}) == 64'd0)
    else $error("result bytes past the count are not zero");

  // No result is valid straight after reset.
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // The queue cannot be full straight after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("request stall after reset");

endmodule

bind salsa20_stream_cipher_top s20sc_checker u_s20sc_checker (.*);
